/* hdl/unsigned_decimal_formatter_macros.svh */
`ifndef UNSIGNED_DECIMAL_FORMATTER_MACROS_SVH
`define UNSIGNED_DECIMAL_FORMATTER_MACROS_SVH

// same-cycle implication
`define UDF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("udf: assertion failed");

// next-cycle implication
`define UDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("udf: assertion failed");

`endif

/* hdl/udf_pkg.sv */
package udf_pkg;

    localparam int CNT_W          = 6;
    localparam int CHAR_W         = 8;
    localparam int BCD_W          = 4;
    localparam int BITS_PER_CYCLE = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

    localparam logic [BCD_W-1:0] DD_LIMIT = 4'd5;
    localparam logic [BCD_W-1:0] DD_ADJ   = 4'd3;

    typedef logic [CNT_W-1:0] cnt_t;

    // run layout: region boundaries as character positions
    typedef struct packed {
        cnt_t ndig;
        cnt_t lead_end;
        cnt_t zero_end;
        cnt_t digit_end;
        cnt_t total;
        logic pad_zero;
    } layout_t;

endpackage

/* hdl/udf_front.sv */
`include "unsigned_decimal_formatter_macros.svh"

module udf_front #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 63,
    parameter int NDIG       = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [VALUE_BITS-1:0]       in_value,
    input  udf_pkg::cnt_t               in_field_width,
    input  udf_pkg::cnt_t               in_precision,
    input  logic                        in_has_precision,
    input  logic                        in_zero_pad,
    input  logic                        in_left_justify,
    output logic                        push,
    input  logic                        q_full,
    output udf_pkg::layout_t            push_layout,
    output logic [NDIG*udf_pkg::BCD_W-1:0] push_digits
);

    localparam int NSTEP    = (VALUE_BITS + udf_pkg::BITS_PER_CYCLE - 1)
                              / udf_pkg::BITS_PER_CYCLE;
    localparam int PAD_BITS = NSTEP * udf_pkg::BITS_PER_CYCLE;
    localparam int DIG_W    = NDIG * udf_pkg::BCD_W;
    localparam int SW       = $clog2(NSTEP);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_FIN, ST_PUSH} state_t;

    state_t                 state_reg;
    logic [SW-1:0]          step_reg;
    logic [PAD_BITS-1:0]    bin_reg;
    logic [DIG_W-1:0]       bcd_reg;
    udf_pkg::cnt_t          width_reg;
    udf_pkg::cnt_t          prec_reg;
    logic                   has_prec_reg;
    logic                   zpad_reg;
    logic                   left_reg;
    udf_pkg::layout_t       layout_reg;

    logic [PAD_BITS-1:0]    bin_next;
    logic [DIG_W-1:0]       bcd_next;
    udf_pkg::layout_t       layout_next;

    // double dabble, four bits per cycle
    always_comb begin
        logic [DIG_W-1:0]    b;
        logic [PAD_BITS-1:0] v;
        b = bcd_reg;
        v = bin_reg;
        for (int s = 0; s < udf_pkg::BITS_PER_CYCLE; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (b[d*udf_pkg::BCD_W +: udf_pkg::BCD_W] >= udf_pkg::DD_LIMIT) begin
                    b[d*udf_pkg::BCD_W +: udf_pkg::BCD_W] =
                        b[d*udf_pkg::BCD_W +: udf_pkg::BCD_W] + udf_pkg::DD_ADJ;
                end
            end
            b = {b[DIG_W-2:0], v[PAD_BITS-1]};
            v = {v[PAD_BITS-2:0], 1'b0};
        end
        bcd_next = b;
        bin_next = v;
    end

    // digit count and run layout
    always_comb begin
        logic          nz_found;
        udf_pkg::cnt_t top;
        udf_pkg::cnt_t ndig;
        udf_pkg::cnt_t body;
        udf_pkg::cnt_t pad;
        udf_pkg::cnt_t lead;
        nz_found = 1'b0;
        top      = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[d*udf_pkg::BCD_W +: udf_pkg::BCD_W] != '0) begin
                nz_found = 1'b1;
                top      = udf_pkg::CNT_W'(d + 1);
            end
        end
        ndig = nz_found ? top : udf_pkg::cnt_t'(1);
        if (has_prec_reg && (prec_reg == '0) && !nz_found) begin
            ndig = '0;
        end
        body = (has_prec_reg && (prec_reg > ndig)) ? prec_reg : ndig;
        pad  = (width_reg > body) ? (width_reg - body) : '0;
        lead = left_reg ? '0 : pad;
        layout_next.ndig      = ndig;
        layout_next.lead_end  = lead;
        layout_next.zero_end  = lead + (body - ndig);
        layout_next.digit_end = lead + body;
        layout_next.total     = body + pad;
        layout_next.pad_zero  = zpad_reg && !left_reg && !has_prec_reg;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign push        = (state_reg == ST_PUSH) && !q_full;
    assign push_layout = layout_reg;
    assign push_digits = bcd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        bin_reg      <= PAD_BITS'(in_value);
                        bcd_reg      <= '0;
                        step_reg     <= SW'(NSTEP - 1);
                        width_reg    <= (in_field_width > udf_pkg::CNT_W'(MAX_FIELD))
                                        ? udf_pkg::CNT_W'(MAX_FIELD) : in_field_width;
                        prec_reg     <= (in_precision > udf_pkg::CNT_W'(MAX_FIELD))
                                        ? udf_pkg::CNT_W'(MAX_FIELD) : in_precision;
                        has_prec_reg <= in_has_precision;
                        zpad_reg     <= in_zero_pad;
                        left_reg     <= in_left_justify;
                        state_reg    <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    bin_reg  <= bin_next;
                    bcd_reg  <= bcd_next;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    layout_reg <= layout_next;
                    state_reg  <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!q_full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `UDF_ASSERT_IMPL(front_no_push_when_full, aclk, aresetn, push, !q_full)
    `UDF_ASSERT_IMPL(front_layout_fits, aclk, aresetn, push, (layout_reg.digit_end <= layout_reg.total))

endmodule

/* hdl/udf_queue.sv */
`include "unsigned_decimal_formatter_macros.svh"

module udf_queue #(
    parameter int DIG_W = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  udf_pkg::layout_t  push_layout,
    input  logic [DIG_W-1:0]  push_digits,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output udf_pkg::layout_t  pop_layout,
    output logic [DIG_W-1:0]  pop_digits
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    udf_pkg::layout_t  layout_mem [DEPTH];
    logic [DIG_W-1:0]  digit_mem  [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign pop_layout = layout_mem[rd_ptr_reg];
    assign pop_digits = digit_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            layout_mem[wr_ptr_reg] <= push_layout;
            digit_mem[wr_ptr_reg]  <= push_digits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `UDF_ASSERT_IMPL(queue_no_underflow, aclk, aresetn, pop, not_empty)
    `UDF_ASSERT_IMPL(queue_count_bound, aclk, aresetn, 1'b1, (count_reg <= CW'(DEPTH)))

endmodule

/* hdl/udf_back.sv */
`include "unsigned_decimal_formatter_macros.svh"

module udf_back #(
    parameter int NDIG = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  udf_pkg::layout_t                q_layout,
    input  logic [NDIG*udf_pkg::BCD_W-1:0]  q_digits,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [udf_pkg::CHAR_W-1:0]      out_char,
    output logic                            out_char_valid,
    output logic                            out_is_last,
    output udf_pkg::cnt_t                   out_total_count
);

    localparam int DIG_W = NDIG * udf_pkg::BCD_W;
    localparam int DI_W  = $clog2(NDIG);

    logic                         busy_reg;
    udf_pkg::layout_t             lay_reg;
    logic [DIG_W-1:0]             dig_reg;
    udf_pkg::cnt_t                k_reg;
    logic [DI_W-1:0]              didx_reg;
    logic                         m_valid_reg;
    logic [udf_pkg::CHAR_W-1:0]   char_reg;
    logic                         char_valid_reg;
    logic                         last_reg;
    udf_pkg::cnt_t                total_reg;

    logic                         emit;
    logic                         in_digit;
    logic                         last_next;
    logic [udf_pkg::CHAR_W-1:0]   char_next;

    assign q_pop = !busy_reg && q_valid;
    assign emit  = busy_reg && (!m_valid_reg || out_ready);

    assign in_digit  = (k_reg >= lay_reg.zero_end) && (k_reg < lay_reg.digit_end);
    assign last_next = (lay_reg.total == '0) || ((k_reg + 1'b1) == lay_reg.total);

    always_comb begin
        if (lay_reg.total == '0) begin
            char_next = udf_pkg::CHAR_NONE;
        end else if (k_reg < lay_reg.lead_end) begin
            char_next = lay_reg.pad_zero ? udf_pkg::ASCII_ZERO : udf_pkg::ASCII_SPACE;
        end else if (k_reg < lay_reg.zero_end) begin
            char_next = udf_pkg::ASCII_ZERO;
        end else if (in_digit) begin
            char_next = udf_pkg::ASCII_ZERO
                      | udf_pkg::CHAR_W'(dig_reg[didx_reg*udf_pkg::BCD_W +: udf_pkg::BCD_W]);
        end else begin
            char_next = udf_pkg::ASCII_SPACE;
        end
    end

    assign out_valid       = m_valid_reg;
    assign out_char        = char_reg;
    assign out_char_valid  = char_valid_reg;
    assign out_is_last     = last_reg;
    assign out_total_count = total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                lay_reg  <= q_layout;
                dig_reg  <= q_digits;
                k_reg    <= '0;
                didx_reg <= DI_W'(q_layout.ndig - 1'b1);
            end
            if (emit) begin
                m_valid_reg    <= 1'b1;
                char_reg       <= char_next;
                char_valid_reg <= (lay_reg.total != '0);
                last_reg       <= last_next;
                total_reg      <= lay_reg.total;
                k_reg          <= k_reg + 1'b1;
                if (in_digit) begin
                    didx_reg <= didx_reg - 1'b1;
                end
                if (last_next) begin
                    busy_reg <= 1'b0;
                end
            end else if (m_valid_reg && out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `UDF_ASSERT_IMPL(back_empty_item_shape, aclk, aresetn, (m_valid_reg && !char_valid_reg), (last_reg && (total_reg == '0)))
    `UDF_ASSERT_NEXT(back_pop_starts_run, aclk, aresetn, q_pop, busy_reg)

endmodule

/* hdl/unsigned_decimal_formatter.sv */
// order: the value is converted from binary to bcd at four bits per cycle, the run layout
// is registered, the result is queued, and the first character is registered on the output
// flow: the front takes a new value only once it has pushed the last one; the back takes
// a new value only after the last character of the one before, at one character per cycle
// while the output is ready; a two-entry queue couples them
// reset: synchronous active-low aresetn clears the front state, the queue and the
// output valid; no transaction is pending after reset
module unsigned_decimal_formatter #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 63
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [VALUE_BITS-1:0]       s_value,
    input  logic [5:0]                  s_field_width,
    input  logic [5:0]                  s_precision,
    input  logic                        s_has_precision,
    input  logic                        s_zero_pad,
    input  logic                        s_left_justify,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_char,
    output logic                        m_char_valid,
    output logic                        m_is_last,
    output logic [5:0]                  m_total_count
);

    localparam int NDIG  = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int DIG_W = NDIG * udf_pkg::BCD_W;

    logic              push;
    logic              q_full;
    udf_pkg::layout_t  push_layout;
    logic [DIG_W-1:0]  push_digits;
    logic              q_pop;
    logic              q_valid;
    udf_pkg::layout_t  pop_layout;
    logic [DIG_W-1:0]  pop_digits;

    udf_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD),
        .NDIG       (NDIG)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_value         (s_value),
        .in_field_width   (s_field_width),
        .in_precision     (s_precision),
        .in_has_precision (s_has_precision),
        .in_zero_pad      (s_zero_pad),
        .in_left_justify  (s_left_justify),
        .push             (push),
        .q_full           (q_full),
        .push_layout      (push_layout),
        .push_digits      (push_digits)
    );

    udf_queue #(
        .DIG_W (DIG_W)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_layout (push_layout),
        .push_digits (push_digits),
        .full        (q_full),
        .pop         (q_pop),
        .not_empty   (q_valid),
        .pop_layout  (pop_layout),
        .pop_digits  (pop_digits)
    );

    udf_back #(
        .NDIG (NDIG)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_layout        (pop_layout),
        .q_digits        (pop_digits),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_char        (m_out_char),
        .out_char_valid  (m_char_valid),
        .out_is_last     (m_is_last),
        .out_total_count (m_total_count)
    );

endmodule
